@@ rtl/fenwick_range_add_point_query_defines.svh @@
// Assertion helpers for the Fenwick range-add block.
`ifndef FENWICK_RANGE_ADD_POINT_QUERY_DEFINES_SVH
`define FENWICK_RANGE_ADD_POINT_QUERY_DEFINES_SVH

// Same-cycle implication.
`define FRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fra_pkg.sv @@
package fra_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int IDX_W        = 10;
   localparam int DATA_W       = 32;

   // sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic clearing;
   } fra_stat_type;

endpackage

@@ rtl/fra_if.sv @@
interface fra_req_if import fra_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [IDX_W-1:0]         index;
   logic [IDX_W-1:0]         last;
   logic signed [DATA_W-1:0] amount;

   modport source (output valid, output action, output index, output last,
                   output amount, input ready);
   modport sink   (input valid, input action, input index, input last,
                   input amount, output ready);
endinterface

interface fra_rsp_if import fra_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] point_value;

   modport source (output valid, output point_value, input ready);
   modport sink   (input valid, input point_value, output ready);
endinterface

@@ rtl/fra_tree_mem.sv @@
module fra_tree_mem import fra_pkg::*; #(
   parameter int DEPTH  = CAPACITY_DEF,
   parameter int ADDR_W = $clog2(CAPACITY_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fra_ctrl.sv @@
module fra_ctrl import fra_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ADDR_W   = $clog2(CAPACITY_DEF),
   parameter int SLOT_W   = IDX_W + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              action,
   input  logic [IDX_W-1:0]  index,
   input  logic [IDX_W-1:0]  last,
   input  logic [DATA_W-1:0] amount,
   input  logic              out_free,
   output fra_stat_type      stat,
   output logic              res_valid,
   output logic [DATA_W-1:0] res_value,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [DATA_W-1:0] mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [DATA_W-1:0] mem_rdata
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   localparam logic [SLOT_W-1:0] CAP_SLOT = SLOT_W'(CAPACITY);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [SLOT_W-1:0] pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [SLOT_W-1:0] second_ff, second_in;
   logic              need2_ff, need2_in;
   logic              query_ff, query_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   logic [SLOT_W-1:0] lowbit;
   logic [SLOT_W-1:0] first_slot;
   logic [SLOT_W-1:0] end_slot;
   logic              in_range;

   assign first_slot = SLOT_W'(index) + SLOT_W'(1);
   assign end_slot   = SLOT_W'(last) + SLOT_W'(2);
   assign lowbit     = walk_ff & (~walk_ff + SLOT_W'(1));
   assign in_range   = query_ff ? (walk_ff != '0)
                                : ((walk_ff != '0) && (walk_ff <= CAP_SLOT));

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      walk_in     = walk_ff;
      pend_in     = pend_ff;
      pend_vld_in = 1'b0;
      second_in   = second_ff;
      need2_in    = need2_ff;
      query_in    = query_ff;
      delta_in    = delta_ff;
      acc_in      = acc_ff;
      res_valid   = 1'b0;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = ADDR_W'(pend_ff - SLOT_W'(1));
      mem_wdata   = mem_rdata + delta_ff;
      mem_raddr   = ADDR_W'(walk_ff - SLOT_W'(1));

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               query_in  = action;
               delta_in  = amount;
               acc_in    = '0;
               second_in = end_slot;
               need2_in  = !action && (end_slot <= CAP_SLOT);
               if (action && (first_slot > CAP_SLOT)) begin
                  walk_in = CAP_SLOT;
               end else begin
                  walk_in = first_slot;
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // data of the slot read last cycle lands now
            if (pend_vld_ff) begin
               if (query_ff) begin
                  acc_in = acc_ff + mem_rdata;
               end else begin
                  mem_we = 1'b1;
               end
            end
            if (in_range) begin
               mem_re      = 1'b1;
               pend_in     = walk_ff;
               pend_vld_in = 1'b1;
               walk_in     = query_ff ? (walk_ff - lowbit) : (walk_ff + lowbit);
            end else if (need2_ff) begin
               walk_in  = second_ff;
               need2_in = 1'b0;
               delta_in = '0 - delta_ff;
            end else if (query_ff) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_value     = acc_in;
   assign stat.busy     = (state_ff != ST_IDLE);
   assign stat.clearing = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pend_vld_ff <= 1'b0;
         need2_ff    <= 1'b0;
         query_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pend_vld_ff <= pend_vld_in;
         need2_ff    <= need2_in;
         query_ff    <= query_in;
      end
      walk_ff   <= walk_in;
      pend_ff   <= pend_in;
      second_ff <= second_in;
      delta_ff  <= delta_in;
      acc_ff    <= acc_in;
   end

endmodule

@@ rtl/fenwick_range_add_point_query.sv @@
// Range add: upward walks from index+1 and, if last+2 <= CAP, last+2 (<= log2(CAP)+1 steps).
// Query: downward walk from slot index+1, capped at CAP; the result goes to the output register.
// Throughput: one item at a time, set by the single walk engine over the tree memory.
// Reset (synchronous, active high): a clearing pass writes zero to all CAPACITY entries
// (1024 by default), one per cycle, with req ready held low.
`include "fenwick_range_add_point_query_defines.svh"

module fenwick_range_add_point_query import fra_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fra_req_if.sink   req_bus,
   fra_rsp_if.source rsp_bus
);

   // tree slots are 1..CAPACITY, memory address is slot-1
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // slot arithmetic must hold index+1, last+2 and one upward step past CAPACITY
   localparam int BASE_W = ($clog2(CAPACITY + 1) > IDX_W + 1) ? $clog2(CAPACITY + 1)
                                                              : IDX_W + 1;
   localparam int SLOT_W = BASE_W + 1;

   fra_stat_type      stat;
   logic              accept;
   logic              out_free;
   logic              res_valid;
   logic [DATA_W-1:0] res_value;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [DATA_W-1:0] mem_rdata;

   // output register: a finished query waits here while the next beat is taken
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   assign req_bus.ready = !stat.busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   fra_ctrl #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .SLOT_W   (SLOT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .action    (req_bus.action),
      .index     (req_bus.index),
      .last      (req_bus.last),
      .amount    (req_bus.amount),
      .out_free  (out_free),
      .stat      (stat),
      .res_valid (res_valid),
      .res_value (res_value),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // one write port and one registered read port; a walk never reads the slot it writes
   fra_tree_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_value = rsp_value_ff;

   // a finished query is only handed over when the output register can take it
   `FRA_ASSERT_NOW(a_res_room, clock, reset, res_valid, out_free, "result with output full")
   // an accepted beat always starts work
   `FRA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, stat.busy, "accepted beat left idle")
   // nothing enters or leaves during the clearing pass
   `FRA_ASSERT_NOW(a_clear_quiet, clock, reset, stat.clearing,
                   !req_bus.ready && !res_valid, "traffic during clearing pass")

endmodule

@@ sim/fra_tb_pkg.sv @@
package fra_tb_pkg;

   typedef enum logic {
      ACT_ADD   = 1'b0,
      ACT_QUERY = 1'b1
   } fra_action_type;

endpackage

@@ sim/fra_point_value_check.sv @@
module fra_point_value_check import fra_pkg::*, fra_tb_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   fra_req_if   req_bus,
   fra_rsp_if   rsp_bus,
   output int   fail_count,
   output int   values_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow tree, slots 1..CAPACITY
   logic [DATA_W-1:0] tree_shadow [0:CAPACITY];
   logic [DATA_W-1:0] point_values_due [$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void shadow_update(input int unsigned slot, input logic [DATA_W-1:0] delta);
      int unsigned pos;
      pos = slot;
      while (pos >= 1 && pos <= CAPACITY) begin
         tree_shadow[pos] += delta;
         pos += pos & (~pos + 1);
      end
   endfunction

   function automatic logic [DATA_W-1:0] shadow_prefix(input int unsigned slot);
      int unsigned pos;
      logic [DATA_W-1:0] acc;
      acc = '0;
      pos = (slot > CAPACITY) ? CAPACITY : slot;
      while (pos > 0) begin
         acc += tree_shadow[pos];
         pos -= pos & (~pos + 1);
      end
      return acc;
   endfunction

   function automatic void shadow_range_add(input logic [IDX_W-1:0] first,
                                            input logic [IDX_W-1:0] final_pos,
                                            input logic [DATA_W-1:0] amt);
      int unsigned open_slot;
      int unsigned close_slot;
      open_slot  = int'(first) + 1;
      close_slot = int'(final_pos) + 2;
      shadow_update(open_slot, amt);
      if (close_slot <= CAPACITY)
         shadow_update(close_slot, -amt);
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         for (int s = 0; s <= CAPACITY; s++)
            tree_shadow[s] = '0;
         point_values_due.delete();
         fail_count = 0;
      end else begin
         // response side first: a query accepted on this edge can't answer on it
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (point_values_due.size() == 0) begin
               report_mismatch($sformatf("point value %h with nothing due",
                                         rsp_bus.point_value));
            end else begin
               want = point_values_due.pop_front();
               if (rsp_bus.point_value !== want)
                  report_mismatch($sformatf("point value got %h want %h",
                                            rsp_bus.point_value, want));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.action == ACT_ADD)
               shadow_range_add(req_bus.index, req_bus.last, req_bus.amount);
            else
               point_values_due = {point_values_due,
                                   shadow_prefix(int'(req_bus.index) + 1)};
         end
      end
      values_due <= point_values_due.size();
   end

endmodule

@@ sim/fenwick_range_add_point_query_tb.sv @@
module fenwick_range_add_point_query_tb import fra_pkg::*, fra_tb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1325;
   // worst beat: walk plus longest gap plus longest stall; the clearing pass up front
   localparam int CYCLE_LIMIT  = 800_000;
   // longest range add is an 11-step and a 10-step walk plus accept
   localparam int DRAIN_CYCLES = 64;
   localparam logic [IDX_W-1:0] IDX_MAX = '1;

   logic clock;
   logic reset;
   int   fail_count;
   int   values_due;
   int   cycles;

   fra_req_if req_bus ();
   fra_rsp_if rsp_bus ();

   fenwick_range_add_point_query dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   fra_point_value_check checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .values_due (values_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: covers a hung handshake or results that never show up
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d point values still due", cycles, values_due);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver. A beat goes out at a falling edge and is held until
   // the rising edge that sees ready. valid is dropped only in gaps and while
   // the stimulus waits for every due point value, never between other beats.
   // ---------------------------------------------------------------------
   task automatic send_beat(input fra_action_type act, input logic [IDX_W-1:0] idx,
                            input logic [IDX_W-1:0] lst, input logic [DATA_W-1:0] amt);
      @(negedge clock);
      req_bus.valid  = 1'b1;
      req_bus.action = act;
      req_bus.index  = idx;
      req_bus.last   = lst;
      req_bus.amount = amt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic range_add(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lst,
                            input logic [DATA_W-1:0] amt);
      send_beat(ACT_ADD, idx, lst, amt);
   endtask

   // last and amount don't matter to a query; fill them with noise
   task automatic query_point(input logic [IDX_W-1:0] idx);
      send_beat(ACT_QUERY, idx, IDX_W'($urandom), $urandom);
   endtask

   // drop valid with junk on the payload lines
   task automatic go_idle();
      @(negedge clock);
      req_bus.valid  = 1'b0;
      req_bus.action = 1'($urandom);
      req_bus.index  = IDX_W'($urandom);
      req_bus.last   = IDX_W'($urandom);
      req_bus.amount = $urandom;
   endtask

   // bias toward ends of the array and tree-level boundaries
   function automatic logic [IDX_W-1:0] pick_index();
      int k;
      k = $urandom_range(0, IDX_W - 1);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return IDX_MAX;
         2:       return IDX_W'((1 << k) - 1);
         3:       return IDX_W'(1 << k);
         default: return IDX_W'($urandom_range(0, int'(IDX_MAX)));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_amount();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'($urandom_range(0, 32)) - 32'd16;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side: stalls follow their own schedule of modes, from always
   // ready through sparse ready to a flat-out stall.
   // ---------------------------------------------------------------------
   initial begin
      int mode;
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(4, 30) : $urandom_range(8, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = 1'($urandom_range(0, 1));
               2:       rsp_bus.ready = ($urandom_range(0, 7) == 0);
               default: rsp_bus.ready = 1'b0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------------
   initial begin
      int burst_left;
      int gap;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] lst;
      logic [IDX_W-1:0] tmp;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_ADD;
      req_bus.index  = '0;
      req_bus.last   = '0;
      req_bus.amount = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // the clearing pass holds ready low; send_beat simply waits it out

      // --- directed part ---
      query_point('0);                          // fresh tree reads zero
      query_point(IDX_MAX);
      range_add('0, IDX_MAX, 32'h7fff_ffff);    // range to the end: no closing update
      query_point('0);
      query_point(IDX_MAX);
      range_add('0, '0, 32'h8000_0000);         // single position, most negative
      query_point('0);                          // now reads -1
      query_point(10'd1);
      range_add(10'd600, 10'd400, 32'd5);       // reversed range: middle gets -amount
      query_point(10'd500);
      query_point(10'd400);
      query_point(10'd600);
      range_add(IDX_MAX, IDX_MAX, 32'd1);       // top slot only, close skipped
      query_point(IDX_MAX);
      range_add(10'd512, 10'd1022, 32'hdead_beef); // close lands exactly on the last slot
      query_point(10'd511);
      query_point(10'd1022);
      query_point(IDX_MAX);
      range_add('0, IDX_MAX, 32'hffff_ffff);
      range_add(IDX_MAX, '0, 32'h0000_0001);    // fully reversed
      query_point(10'd777);
      query_point(10'd256);
      send_beat(ACT_QUERY, 10'd300, IDX_MAX, 32'hffff_ffff); // ignored fields all ones

      // --- random part ---
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            case ($urandom_range(0, 5))
               0, 1:    gap = 0;
               2, 3:    gap = $urandom_range(1, 4);
               4:       gap = $urandom_range(5, 20);
               default: gap = $urandom_range(21, 60);
            endcase
            if (gap > 0) begin
               go_idle();
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end

         // hold off until the block has answered everything
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
            go_idle();
            wait (values_due == 0);
         end

         if ($urandom_range(0, 99) < 45) begin
            query_point(pick_index());
         end else begin
            idx = pick_index();
            lst = pick_index();
            // mostly ordered ranges, the rest reversed
            if (idx > lst && $urandom_range(0, 3) != 0) begin
               tmp = idx;
               idx = lst;
               lst = tmp;
            end
            range_add(idx, lst, pick_amount());
         end
         burst_left--;
      end

      // --- drain and verdict ---
      go_idle();
      wait (values_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
